[rtl/alr_pkg.sv]
// Shared types and constants for the angular Laplacian recurrence block.
// No dependencies; imported by every module under rtl.
`timescale 1ns / 1ps

package alr_pkg;

   localparam int DATA_WIDTH = 48;                 // Q23.24 coefficient word
   localparam int IDX_WIDTH  = 6;                  // theta and phi mode index
   localparam int SQ_WIDTH   = 2 * IDX_WIDTH;      // j*j and k*k
   localparam int MULN_WIDTH = SQ_WIDTH + 2;       // covers 4*k*k
   localparam int PROD_WIDTH = DATA_WIDTH + MULN_WIDTH + 1;

   typedef logic signed [DATA_WIDTH-1:0] data_type;
   typedef logic        [IDX_WIDTH-1:0]  idx_type;
   typedef logic        [SQ_WIDTH-1:0]   sq_type;
   typedef logic        [MULN_WIDTH-1:0] muln_type;

   localparam data_type DATA_MAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};
   localparam data_type DATA_MIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};

   // integer factors used by the recurrences
   localparam muln_type MUL_DOUBLE  = muln_type'(2);
   localparam muln_type THETA_SHIFT = muln_type'(2);   // the j+2 factor

   typedef struct packed {
      logic clear;   // column start: zero all history
      logic push;    // shift in the finished item
   } hist_ctrl_type;

endpackage

[rtl/alr_alu.sv]
// Shared saturating arithmetic unit: one integer-factor multiplier and one
// add/subtract, both clamped to the data range. Depends on alr_pkg.
`timescale 1ns / 1ps

module alr_alu (
   input  alr_pkg::data_type mul_a,
   input  alr_pkg::muln_type mul_n,
   output alr_pkg::data_type mul_y,
   output logic              mul_sat,
   input  alr_pkg::data_type add_a,
   input  alr_pkg::data_type add_b,
   input  logic              add_sub,
   output alr_pkg::data_type add_y,
   output logic              add_sat
);
   import alr_pkg::*;

   logic signed [PROD_WIDTH-1:0] prod;
   data_type                     prod_lo;
   logic signed [DATA_WIDTH:0]   sum;

   // factor is unsigned, so it gets a zero sign bit
   assign prod    = PROD_WIDTH'(mul_a) * PROD_WIDTH'($signed({1'b0, mul_n}));
   assign prod_lo = prod[DATA_WIDTH-1:0];
   assign mul_sat = (prod != PROD_WIDTH'(prod_lo));

   always_comb begin
      if (mul_sat) begin
         mul_y = prod[PROD_WIDTH-1] ? DATA_MIN : DATA_MAX;
      end else begin
         mul_y = prod_lo;
      end
   end

   assign sum = add_sub ? ((DATA_WIDTH+1)'(add_a) - (DATA_WIDTH+1)'(add_b))
                        : ((DATA_WIDTH+1)'(add_a) + (DATA_WIDTH+1)'(add_b));
   assign add_sat = (sum[DATA_WIDTH] != sum[DATA_WIDTH-1]);

   always_comb begin
      if (add_sat) begin
         add_y = sum[DATA_WIDTH] ? DATA_MIN : DATA_MAX;
      end else begin
         add_y = sum[DATA_WIDTH-1:0];
      end
   end

endmodule

[rtl/alr_history.sv]
// Delay lines of the coefficient, cot-derivative term and 1/sin^2 term.
// Depends on alr_pkg.
`timescale 1ns / 1ps

module alr_history (
   input  logic                   clock,
   input  logic                   reset,
   input  alr_pkg::hist_ctrl_type ctrl,
   input  alr_pkg::data_type      coeff_new,
   input  alr_pkg::data_type      cot_new,
   input  alr_pkg::data_type      sin_new,
   output alr_pkg::data_type      coeff_back2,
   output alr_pkg::data_type      cot_back2,
   output alr_pkg::data_type      sin_back2,
   output alr_pkg::data_type      sin_back4
);
   import alr_pkg::*;

   data_type coeff_ff [2];
   data_type cot_ff   [2];
   data_type sin_ff   [4];

   always_ff @(posedge clock) begin
      if (reset || ctrl.clear) begin
         coeff_ff <= '{default: '0};
         cot_ff   <= '{default: '0};
         sin_ff   <= '{default: '0};
      end else if (ctrl.push) begin
         coeff_ff[1] <= coeff_ff[0];
         coeff_ff[0] <= coeff_new;
         cot_ff[1]   <= cot_ff[0];
         cot_ff[0]   <= cot_new;
         sin_ff[3]   <= sin_ff[2];
         sin_ff[2]   <= sin_ff[1];
         sin_ff[1]   <= sin_ff[0];
         sin_ff[0]   <= sin_new;
      end
   end

   assign coeff_back2 = coeff_ff[1];
   assign cot_back2   = cot_ff[1];
   assign sin_back2   = sin_ff[1];
   assign sin_back4   = sin_ff[3];

endmodule

[rtl/angular_laplacian_recurrence.sv]
// Top level of the angular Laplacian recurrence: sequencer, operand muxing
// and output register. Depends on alr_pkg, alr_alu and alr_history.
`timescale 1ns / 1ps

// Each request transaction carries one Q23.24 coefficient of a column, theta
// index descending, and yields exactly one response transaction with the
// saturated Laplacian coefficient and a flag that is set when any step clamped.
// A transaction runs from acceptance through ST_MUL0 and ST_STEP1 to ST_STEP7
// to a loaded result: the five products and six sums run in sequence through
// one saturating multiplier and one adder, and req_ready is high only while the
// sequencer is idle. The result sits in an output register, so the next request
// is taken while the previous response waits; a new result waits in the last
// step until that register is free. column_start on a request clears the
// history before the item is used.

module angular_laplacian_recurrence (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  alr_pkg::data_type req_coeff_in,
   input  alr_pkg::idx_type  req_theta_index,
   input  alr_pkg::idx_type  req_phi_index,
   input  logic              req_column_start,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output alr_pkg::data_type rsp_lapf_out,
   output logic              rsp_saturated
);
   import alr_pkg::*;

   typedef enum logic [8:0] {
      ST_IDLE  = 9'b000000001,
      ST_MUL0  = 9'b000000010,
      ST_STEP1 = 9'b000000100,
      ST_STEP2 = 9'b000001000,
      ST_STEP3 = 9'b000010000,
      ST_STEP4 = 9'b000100000,
      ST_STEP5 = 9'b001000000,
      ST_STEP6 = 9'b010000000,
      ST_STEP7 = 9'b100000000
   } state_type;

   state_type state_ff, state_in;

   data_type f_ff,   f_in;
   idx_type  j_ff,   j_in;
   sq_type   jj_ff,  jj_in;
   muln_type kk4_ff, kk4_in;
   data_type p_ff,   p_in;
   data_type c_ff,   c_in;
   data_type s_ff,   s_in;
   logic     sat_ff, sat_in;
   logic     rsp_valid_ff, rsp_valid_in;
   data_type rsp_lapf_ff,  rsp_lapf_in;
   logic     rsp_sat_ff,   rsp_sat_in;

   sq_type   kk_full;
   logic     j_zero;
   logic     out_free;

   data_type mul_a, mul_y, add_a, add_b, add_y, add_half;
   muln_type mul_n;
   logic     mul_sat, add_sat, add_sub;

   hist_ctrl_type hist_ctrl;
   data_type      f_back2, c_back2, s_back2, s_back4;

   alr_alu u_alu (
      .mul_a   (mul_a),
      .mul_n   (mul_n),
      .mul_y   (mul_y),
      .mul_sat (mul_sat),
      .add_a   (add_a),
      .add_b   (add_b),
      .add_sub (add_sub),
      .add_y   (add_y),
      .add_sat (add_sat)
   );

   alr_history u_history (
      .clock       (clock),
      .reset       (reset),
      .ctrl        (hist_ctrl),
      .coeff_new   (f_ff),
      .cot_new     (c_ff),
      .sin_new     (s_ff),
      .coeff_back2 (f_back2),
      .cot_back2   (c_back2),
      .sin_back2   (s_back2),
      .sin_back4   (s_back4)
   );

   assign req_ready = (state_ff == ST_IDLE);
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign j_zero    = (j_ff == '0);
   assign kk_full   = req_phi_index * req_phi_index;
   assign add_half  = j_zero ? {add_y[DATA_WIDTH-1], add_y[DATA_WIDTH-1:1]} : add_y;

   // operand selection for the shared unit
   always_comb begin
      mul_a   = f_ff;
      mul_n   = muln_type'(j_ff);
      add_a   = c_ff;
      add_b   = p_ff;
      add_sub = 1'b1;
      case (state_ff)
         ST_MUL0: begin
            mul_a = f_ff;
            mul_n = muln_type'(j_ff);
         end
         ST_STEP1: begin
            mul_a = f_back2;
            mul_n = muln_type'(j_ff) + THETA_SHIFT;
            add_a = c_back2;
         end
         ST_STEP2: begin
            mul_a = f_back2;
            mul_n = kk4_ff;
         end
         ST_STEP3: begin
            mul_a = s_back2;
            mul_n = MUL_DOUBLE;
         end
         ST_STEP4: begin
            mul_a   = f_ff;
            mul_n   = muln_type'(jj_ff);
            add_a   = s_ff;
            add_sub = 1'b0;
         end
         ST_STEP5: begin
            add_a = s_ff;
            add_b = s_back4;
         end
         ST_STEP7: begin
            add_a   = p_ff;
            add_b   = s_ff;
            add_sub = 1'b0;
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      state_in     = state_ff;
      f_in         = f_ff;
      j_in         = j_ff;
      jj_in        = jj_ff;
      kk4_in       = kk4_ff;
      p_in         = p_ff;
      c_in         = c_ff;
      s_in         = s_ff;
      sat_in       = sat_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_lapf_in  = rsp_lapf_ff;
      rsp_sat_in   = rsp_sat_ff;
      hist_ctrl    = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               f_in            = req_coeff_in;
               j_in            = req_theta_index;
               jj_in           = req_theta_index * req_theta_index;
               kk4_in          = {kk_full, 2'b00};
               sat_in          = 1'b0;
               hist_ctrl.clear = req_column_start;
               state_in        = ST_MUL0;
            end
         end
         ST_MUL0: begin
            p_in     = mul_y;
            sat_in   = sat_ff | mul_sat;
            state_in = ST_STEP1;
         end
         ST_STEP1: begin
            c_in     = add_y;
            p_in     = mul_y;
            sat_in   = sat_ff | mul_sat | add_sat;
            state_in = ST_STEP2;
         end
         ST_STEP2: begin
            c_in     = add_half;
            p_in     = mul_y;
            sat_in   = sat_ff | mul_sat | add_sat;
            state_in = ST_STEP3;
         end
         ST_STEP3: begin
            s_in     = p_ff;
            p_in     = mul_y;
            sat_in   = sat_ff | mul_sat;
            state_in = ST_STEP4;
         end
         ST_STEP4: begin
            s_in     = add_y;
            p_in     = mul_y;
            sat_in   = sat_ff | mul_sat | add_sat;
            state_in = ST_STEP5;
         end
         ST_STEP5: begin
            s_in     = add_half;
            sat_in   = sat_ff | add_sat;
            state_in = ST_STEP6;
         end
         ST_STEP6: begin
            // p now holds C - j*j*f; c stays for the history
            p_in     = add_y;
            sat_in   = sat_ff | add_sat;
            state_in = ST_STEP7;
         end
         ST_STEP7: begin
            if (out_free) begin
               rsp_valid_in   = 1'b1;
               rsp_lapf_in    = add_y;
               rsp_sat_in     = sat_ff | add_sat;
               hist_ctrl.push = 1'b1;
               state_in       = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      f_ff        <= f_in;
      j_ff        <= j_in;
      jj_ff       <= jj_in;
      kk4_ff      <= kk4_in;
      p_ff        <= p_in;
      c_ff        <= c_in;
      s_ff        <= s_in;
      sat_ff      <= sat_in;
      rsp_lapf_ff <= rsp_lapf_in;
      rsp_sat_ff  <= rsp_sat_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_lapf_out  = rsp_lapf_ff;
   assign rsp_saturated = rsp_sat_ff;

endmodule
